[hdl/glpe_pkg.sv]
package glpe_pkg;

  // Default sizes of the dictionary and the string cap.
  localparam int DictSlots = 8192;
  localparam int MaxRun    = 97;

  // Dictionary entry: valid bit, key (prefix code and pixel), assigned code.
  localparam int EntryW = 33;

  // Fixed LZW codes and limits.
  localparam logic [11:0] ClearCode   = 12'd256;
  localparam logic [11:0] EndCode     = 12'd257;
  localparam logic [3:0]  StartWidth  = 4'd9;
  localparam logic [3:0]  MaxWidth    = 4'd12;
  localparam logic [11:0] CodeLimit   = 12'd4093;
  localparam logic [11:0] InsertLimit = 12'd3335;
  localparam logic [13:0] StoreLimit  = 14'd15379;
  localparam logic [15:0] HashMult    = 16'd40503;

  // Input and output transaction payloads.
  typedef struct packed {
    logic [7:0] pixel;
    logic       last_pixel;
  } in_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       run_last;
    logic       image_done;
  } out_t;

  // Commands from the sequencer to the bit packer.
  typedef enum logic [1:0] {
    CMD_CODE,
    CMD_PAD,
    CMD_END
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [11:0] code;
    logic [3:0]  width;
    logic        done;
  } cmd_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR0,
    S_EXT,
    S_RED,
    S_RD,
    S_CHK,
    S_EMIT_PFX,
    S_EMIT_PIX,
    S_EMIT_CLR,
    S_SWEEP,
    S_TAIL,
    S_FLUSH,
    S_LEND,
    S_PAD,
    S_PEND
  } state_e;

endpackage

[hdl/glpe_ram.sv]
module glpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Single port, registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[hdl/glpe_packer.sv]
module glpe_packer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  glpe_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  output glpe_pkg::out_t out_data_o,
  output logic           out_valid_o,
  input  logic           out_ready_i
);
  import glpe_pkg::*;

  logic [18:0] acc_q, acc_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        hold_valid_q, hold_valid_d;
  logic [7:0]  hold_q, hold_d;
  logic        ov_q, ov_d;
  out_t        od_q, od_d;
  logic        out_free, byte_go, cmd_go;

  // A finished byte waits in the hold register until we know whether it ends the pixel.
  assign out_free    = !ov_q || out_ready_i;
  assign byte_go     = (cnt_q >= 5'd8) && (!hold_valid_q || out_free);
  assign cmd_ready_o = (cnt_q < 5'd8) && (!hold_valid_q || out_free);
  assign cmd_go      = cmd_valid_i && cmd_ready_o;

  always_comb begin
    acc_d        = acc_q;
    cnt_d        = cnt_q;
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    ov_d         = ov_q && !out_ready_i;
    od_d         = od_q;
    if (byte_go) begin
      if (hold_valid_q) begin
        ov_d = 1'b1;
        od_d = '{code_byte: hold_q, run_last: 1'b0, image_done: 1'b0};
      end
      hold_d       = acc_q[7:0];
      hold_valid_d = 1'b1;
      acc_d        = acc_q >> 8;
      cnt_d        = cnt_q - 5'd8;
    end else if (cmd_go) begin
      unique case (cmd_i.kind)
        CMD_CODE: begin
          acc_d = acc_q | (19'(cmd_i.code) << cnt_q[2:0]);
          cnt_d = cnt_q + 5'(cmd_i.width);
        end
        CMD_PAD: begin
          if (cnt_q != 5'd0) begin
            cnt_d = 5'd8;
          end
        end
        CMD_END: begin
          if (hold_valid_q) begin
            ov_d         = 1'b1;
            od_d         = '{code_byte: hold_q, run_last: 1'b1, image_done: cmd_i.done};
            hold_valid_d = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      cnt_q        <= '0;
      hold_valid_q <= 1'b0;
      ov_q         <= 1'b0;
    end else begin
      acc_q        <= acc_d;
      cnt_q        <= cnt_d;
      hold_valid_q <= hold_valid_d;
      ov_q         <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    od_q   <= od_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

endmodule

[hdl/glpe_engine.sv]
module glpe_engine #(
  parameter int DICT_SLOTS = glpe_pkg::DictSlots,
  parameter int MAX_RUN    = glpe_pkg::MaxRun
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  glpe_pkg::in_t  in_data_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output glpe_pkg::cmd_t cmd_o,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i
);
  import glpe_pkg::*;

  localparam int  SW        = $clog2(DICT_SLOTS);
  localparam logic [SW-1:0] LastSlot = SW'(DICT_SLOTS - 1);
  localparam logic [SW:0]   SlotsW   = (SW + 1)'(DICT_SLOTS);

  state_e            state_q, state_d;
  logic [7:0]        pixel_q, pixel_d;
  logic              last_q, last_d;
  logic [11:0]       prefix_q, prefix_d;
  logic [6:0]        len_q, len_d;
  logic [11:0]       assigned_q, assigned_d;
  logic [11:0]       inserted_q, inserted_d;
  logic [13:0]       store_q, store_d;
  logic [3:0]        width_q, width_d;
  logic              started_q, started_d;
  logic              hit_q, hit_d;
  logic              ret_tail_q, ret_tail_d;
  logic [35:0]       prod_q, prod_d;
  logic [SW-1:0]     slot_q, slot_d;

  logic              mem_we;
  logic [EntryW-1:0] mem_wdata, mem_rdata;
  logic [19:0]       key;
  logic [11:0]       newcode;
  logic [11:0]       ins_new;
  logic [13:0]       store_new;
  logic [SW:0]       prod_low;
  logic [SW-1:0]     slot_next;

  glpe_ram #(
    .WIDTH (EntryW),
    .DEPTH (DICT_SLOTS)
  ) u_dict (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (slot_q),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign key       = {prefix_q, pixel_q};
  assign newcode   = assigned_q + 12'd1 + EndCode;
  assign ins_new   = hit_q ? inserted_q : inserted_q + 12'd1;
  assign store_new = hit_q ? store_q : store_q + 14'(len_q) + 14'd3;
  assign prod_low  = {1'b0, prod_q[SW-1:0]};
  assign slot_next = (slot_q == LastSlot) ? '0 : slot_q + SW'(1);

  // Sequencer: hash, probe, insert, and code emission.
  always_comb begin
    state_d    = state_q;
    pixel_d    = pixel_q;
    last_d     = last_q;
    prefix_d   = prefix_q;
    len_d      = len_q;
    assigned_d = assigned_q;
    inserted_d = inserted_q;
    store_d    = store_q;
    width_d    = width_q;
    started_d  = started_q;
    hit_d      = hit_q;
    ret_tail_d = ret_tail_q;
    prod_d     = prod_q;
    slot_d     = slot_q;
    mem_we     = 1'b0;
    mem_wdata  = '0;
    in_ready_o = 1'b0;
    cmd_valid_o = 1'b0;
    cmd_o      = '{kind: CMD_CODE, code: prefix_q, width: width_q, done: 1'b0};

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          pixel_d = in_data_i.pixel;
          last_d  = in_data_i.last_pixel;
          state_d = started_q ? S_EXT : S_CLR0;
        end
      end
      S_CLR0: begin
        cmd_valid_o = 1'b1;
        cmd_o.code  = ClearCode;
        if (cmd_ready_i) begin
          started_d = 1'b1;
          state_d   = S_EXT;
        end
      end
      S_EXT: begin
        len_d = len_q + 7'd1;
        if (len_q == 7'd0) begin
          prefix_d = {4'd0, pixel_q};
          state_d  = S_TAIL;
        end else begin
          prod_d   = 36'(key) * 36'(HashMult);
          state_d  = S_RED;
        end
      end
      S_RED: begin
        // The low hash bits are below twice the slot count, so one subtract folds them in.
        slot_d  = (prod_low >= SlotsW) ? SW'(prod_low - SlotsW) : prod_q[SW-1:0];
        state_d = S_RD;
      end
      S_RD: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        if (!mem_rdata[EntryW-1]) begin
          hit_d   = 1'b0;
          state_d = S_EMIT_PFX;
        end else if (mem_rdata[31:12] == key) begin
          if (len_q < 7'(MAX_RUN)) begin
            prefix_d = mem_rdata[11:0];
            state_d  = S_TAIL;
          end else begin
            hit_d   = 1'b1;
            state_d = S_EMIT_PFX;
          end
        end else begin
          slot_d  = slot_next;
          state_d = S_RD;
        end
      end
      S_EMIT_PFX: begin
        cmd_valid_o = 1'b1;
        if (cmd_ready_i) begin
          assigned_d = assigned_q + 12'd1;
          inserted_d = ins_new;
          store_d    = store_new;
          if (!hit_q) begin
            mem_we    = 1'b1;
            mem_wdata = {1'b1, key, newcode};
          end
          len_d    = 7'd1;
          prefix_d = {4'd0, pixel_q};
          if (width_q < MaxWidth && {1'b0, newcode} == (13'd1 << width_q)) begin
            width_d = width_q + 4'd1;
          end
          if (newcode > CodeLimit || ins_new > InsertLimit || store_new > StoreLimit) begin
            state_d = S_EMIT_PIX;
          end else begin
            state_d = S_TAIL;
          end
        end
      end
      S_EMIT_PIX: begin
        cmd_valid_o = 1'b1;
        if (cmd_ready_i) begin
          state_d = S_EMIT_CLR;
        end
      end
      S_EMIT_CLR: begin
        cmd_valid_o = 1'b1;
        cmd_o.code  = ClearCode;
        if (cmd_ready_i) begin
          assigned_d = '0;
          inserted_d = '0;
          store_d    = 14'd1;
          len_d      = '0;
          width_d    = StartWidth;
          ret_tail_d = 1'b1;
          slot_d     = '0;
          state_d    = S_SWEEP;
        end
      end
      S_SWEEP: begin
        mem_we = 1'b1;
        slot_d = slot_next;
        if (slot_q == LastSlot) begin
          state_d = ret_tail_q ? S_TAIL : S_IDLE;
        end
      end
      S_TAIL: begin
        if (!last_q) begin
          state_d = S_PEND;
        end else if (len_q != 7'd0) begin
          state_d = S_FLUSH;
        end else begin
          state_d = S_LEND;
        end
      end
      S_FLUSH: begin
        cmd_valid_o = 1'b1;
        if (cmd_ready_i) begin
          state_d = S_LEND;
        end
      end
      S_LEND: begin
        cmd_valid_o = 1'b1;
        cmd_o.code  = EndCode;
        if (cmd_ready_i) begin
          state_d = S_PAD;
        end
      end
      S_PAD: begin
        cmd_valid_o = 1'b1;
        cmd_o.kind  = CMD_PAD;
        if (cmd_ready_i) begin
          state_d = S_PEND;
        end
      end
      S_PEND: begin
        cmd_valid_o = 1'b1;
        cmd_o.kind  = CMD_END;
        cmd_o.done  = last_q;
        if (cmd_ready_i) begin
          if (last_q) begin
            // End of image: back to the reset state with a fresh dictionary.
            prefix_d   = '0;
            len_d      = '0;
            assigned_d = '0;
            inserted_d = '0;
            store_d    = 14'd1;
            width_d    = StartWidth;
            started_d  = 1'b0;
            ret_tail_d = 1'b0;
            slot_d     = '0;
            state_d    = S_SWEEP;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_SWEEP;
      prefix_q   <= '0;
      len_q      <= '0;
      assigned_q <= '0;
      inserted_q <= '0;
      store_q    <= 14'd1;
      width_q    <= StartWidth;
      started_q  <= 1'b0;
      ret_tail_q <= 1'b0;
      slot_q     <= '0;
    end else begin
      state_q    <= state_d;
      prefix_q   <= prefix_d;
      len_q      <= len_d;
      assigned_q <= assigned_d;
      inserted_q <= inserted_d;
      store_q    <= store_d;
      width_q    <= width_d;
      started_q  <= started_d;
      ret_tail_q <= ret_tail_d;
      slot_q     <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_q <= pixel_d;
    last_q  <= last_d;
    hit_q   <= hit_d;
    prod_q  <= prod_d;
  end

endmodule

[hdl/gif_lzw_pixel_encoder_top.sv]
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_ready_o | glpe_pkg::in_t (pixel, last_pixel)
// out     | output    | out_valid_o/out_ready_i | glpe_pkg::out_t (code_byte, run_last, image_done)
//
// One pixel at a time: a pixel that starts a string passes accept, extend, tail and close;
// one that extends it passes accept, extend, hash, read, compare, tail and close with a
// single probe. Each further probe repeats read and compare, each emitted code adds an
// emit step, and the packer holds off commands while it moves out each finished byte.
// After reset, after every table clear and after the last pixel of an image, a clearing
// pass writes all DICT_SLOTS entries, one per cycle, while no pixel is accepted.
// The output register stalls the packer, which in turn stalls the sequencer.
module gif_lzw_pixel_encoder_top #(
  parameter int DICT_SLOTS = glpe_pkg::DictSlots,
  parameter int MAX_RUN    = glpe_pkg::MaxRun
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  glpe_pkg::in_t  in_data_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output glpe_pkg::out_t out_data_o,
  output logic           out_valid_o,
  input  logic           out_ready_i
);
  import glpe_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  // Dictionary sequencer.
  glpe_engine #(
    .DICT_SLOTS (DICT_SLOTS),
    .MAX_RUN    (MAX_RUN)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  // Code-to-byte packer with output register.
  glpe_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

endmodule

[hdl/glpe_checker.sv]
module glpe_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input glpe_pkg::in_t  in_data_i,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input glpe_pkg::out_t out_data_o,
  input logic           out_valid_o,
  input logic           out_ready_i
);

  // A stalled output transaction holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  // The final byte of an image also closes its pixel.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.image_done |-> out_data_o.run_last)
    else $error("image_done without run_last");

  // Pixels are processed one at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted on back-to-back cycles");

  // The last pixel of an image always yields at least the end code before more input.
  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last_pixel |=> ##1 !in_ready_o)
    else $error("input accepted right after the last pixel");

endmodule

bind gif_lzw_pixel_encoder_top glpe_checker u_glpe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_data_i   (in_data_i),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_data_o  (out_data_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i)
);

[tb/tb_gif_lzw_pixel_encoder_top.sv]
`timescale 1ns / 100ps

module tb_gif_lzw_pixel_encoder_top;
  import glpe_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int TailWait   = 300;
  localparam int HoldCycles = 400;

  logic clk_i;
  logic rst_ni;
  in_t  in_data_i;
  logic in_valid_i;
  logic in_ready_o;
  out_t out_data_o;
  logic out_valid_o;
  logic out_ready_i;

  gif_lzw_pixel_encoder_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_data_o (out_data_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i)
  );

  // Encoder state mirrored by the byte predictor.
  logic [11:0] code_of[int];
  int unsigned pfx_code;
  int unsigned str_len;
  int unsigned codes_used;
  int unsigned strings_stored;
  int unsigned store_bytes;
  int unsigned width;
  int unsigned acc_bits;
  int unsigned acc_cnt;
  bit          image_open;

  out_t byte_q[$];
  out_t expected_bytes[$];

  int errors;
  int pixels_sent;
  int bytes_seen;
  int images_done;
  int table_clears;
  int cycles;
  bit calm;
  bit hold_req;

  // Packs one code LSB first and queues every completed byte.
  function automatic void pack_code(int unsigned code);
    int unsigned a;
    int unsigned c;
    out_t b;
    a = acc_bits | ((code & 12'hFFF) << acc_cnt);
    c = acc_cnt + width;
    while (c >= 8) begin
      b = '0;
      b.code_byte = a[7:0];
      byte_q.push_back(b);
      a = a >> 8;
      c -= 8;
    end
    acc_bits = a & 8'h7F;
    acc_cnt = c & 7;
  endfunction

  function automatic void restart_table();
    pack_code(ClearCode);
    code_of.delete();
    codes_used = 0;
    strings_stored = 0;
    store_bytes = 1;
    str_len = 0;
    width = StartWidth;
  endfunction

  function automatic void reset_encoder();
    code_of.delete();
    pfx_code = 0;
    str_len = 0;
    codes_used = 0;
    strings_stored = 0;
    store_bytes = 1;
    width = StartWidth;
    acc_bits = 0;
    acc_cnt = 0;
    image_open = 0;
  endfunction

  // Computes the bytes one accepted pixel produces into byte_q.
  function automatic void encode_pixel(in_t d);
    int key;
    bit hit;
    int unsigned next_code;
    out_t b;
    byte_q.delete();
    if (!image_open) begin
      restart_table();
      image_open = 1;
    end
    str_len++;
    if (str_len == 1) begin
      pfx_code = d.pixel;
    end else begin
      key = ((pfx_code & 12'hFFF) << 8) | d.pixel;
      hit = code_of.exists(key);
      if (hit && str_len < MaxRun) begin
        pfx_code = code_of[key];
      end else begin
        pack_code(pfx_code);
        codes_used++;
        next_code = codes_used + EndCode;
        if (!hit) begin
          code_of[key] = next_code[11:0];
          strings_stored++;
          store_bytes += str_len + 3;
        end
        str_len = 1;
        pfx_code = d.pixel;
        if (width < MaxWidth && next_code == (1 << width)) width++;
        if (next_code > CodeLimit || strings_stored > InsertLimit
            || store_bytes > StoreLimit) begin
          pack_code(pfx_code);
          restart_table();
          table_clears++;
        end
      end
    end
    if (d.last_pixel) begin
      if (str_len > 0) pack_code(pfx_code);
      pack_code(EndCode);
      if (acc_cnt > 0) begin
        b = '0;
        b.code_byte = acc_bits[7:0];
        byte_q.push_back(b);
      end
      if (byte_q.size() > 0) byte_q[byte_q.size()-1].image_done = 1'b1;
      reset_encoder();
    end
    if (byte_q.size() > 0) byte_q[byte_q.size()-1].run_last = 1'b1;
  endfunction

  // Clock and cycle limit.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout, %0d bytes still expected", $time, expected_bytes.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: checks each output transaction and stalls at random.
  initial begin : receiver
    int hold_left;
    bit hold_done;
    out_t exp_b;
    hold_left = 0;
    hold_done = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        bytes_seen++;
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte, actual %h", $time, out_data_o);
          errors++;
        end else begin
          exp_b = expected_bytes.pop_front();
          if (out_data_o.code_byte !== exp_b.code_byte) begin
            $display("%0t: code_byte expected %h actual %h", $time,
                     exp_b.code_byte, out_data_o.code_byte);
            errors++;
          end
          if (out_data_o.run_last !== exp_b.run_last) begin
            $display("%0t: run_last expected %b actual %b", $time,
                     exp_b.run_last, out_data_o.run_last);
            errors++;
          end
          if (out_data_o.image_done !== exp_b.image_done) begin
            $display("%0t: image_done expected %b actual %b", $time,
                     exp_b.image_done, out_data_o.image_done);
            errors++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm ? 1'b1 : ($urandom_range(99) >= 16);
      end
    end
  end

  // Offers one pixel transaction and predicts its bytes once accepted.
  task automatic send_pixel(in_t d, int typed_n, logic [7:0] typed[4]);
    out_t b;
    in_data_i <= d;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pixels_sent++;
    if (d.last_pixel) images_done++;
    encode_pixel(d);
    if (typed_n < 0) begin
      foreach (byte_q[i]) expected_bytes.push_back(byte_q[i]);
    end else begin
      for (int i = 0; i < typed_n; i++) begin
        b = '0;
        b.code_byte = typed[i];
        b.run_last = (i == typed_n - 1);
        b.image_done = (i == typed_n - 1);
        expected_bytes.push_back(b);
      end
    end
    if (!calm && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic send_plain(logic [7:0] px, logic lst);
    in_t d;
    logic [7:0] none[4];
    none = '{default: 8'h00};
    d.pixel = px;
    d.last_pixel = lst;
    send_pixel(d, -1, none);
  endtask

  typedef struct {
    logic [7:0] px;
    logic       lst;
    int         n;
    logic [7:0] bytes[4];
  } row_t;

  // Directed rows; the first two are whole images typed in by hand.
  row_t rows[$] = '{
    '{8'h00, 1'b1, 4, '{8'h00, 8'h01, 8'h04, 8'h04}},
    '{8'hFF, 1'b1, 4, '{8'h00, 8'hFF, 8'h05, 8'h04}},
    '{8'h00, 1'b0, -1, '{default: 8'h00}},
    '{8'h00, 1'b0, -1, '{default: 8'h00}},
    '{8'h00, 1'b0, -1, '{default: 8'h00}},
    '{8'h00, 1'b0, -1, '{default: 8'h00}},
    '{8'h00, 1'b0, -1, '{default: 8'h00}},
    '{8'hFF, 1'b0, -1, '{default: 8'h00}},
    '{8'h00, 1'b0, -1, '{default: 8'h00}},
    '{8'hFF, 1'b0, -1, '{default: 8'h00}},
    '{8'h00, 1'b0, -1, '{default: 8'h00}},
    '{8'hFF, 1'b0, -1, '{default: 8'h00}},
    '{8'hAA, 1'b0, -1, '{default: 8'h00}},
    '{8'h55, 1'b0, -1, '{default: 8'h00}},
    '{8'hAA, 1'b0, -1, '{default: 8'h00}},
    '{8'h55, 1'b0, -1, '{default: 8'h00}},
    '{8'h80, 1'b0, -1, '{default: 8'h00}},
    '{8'h01, 1'b0, -1, '{default: 8'h00}},
    '{8'h00, 1'b1, -1, '{default: 8'h00}},
    '{8'h12, 1'b0, -1, '{default: 8'h00}},
    '{8'h12, 1'b1, -1, '{default: 8'h00}}
  };

  // Main sequence.
  initial begin : stimulus
    in_t d;
    int len;
    int alpha;
    int count;
    errors = 0;
    pixels_sent = 0;
    bytes_seen = 0;
    images_done = 0;
    table_clears = 0;
    cycles = 0;
    calm = 0;
    hold_req = 0;
    reset_encoder();
    in_data_i = '0;
    in_valid_i = 1'b0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      d.pixel = rows[i].px;
      d.last_pixel = rows[i].lst;
      send_pixel(d, rows[i].n, rows[i].bytes);
    end

    // Sender pause until every byte has drained.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);

    // Random images, mostly small alphabets so strings grow; receiver holds off early.
    hold_req = 1;
    count = 0;
    while (count < 300) begin
      len = $urandom_range(15, 90);
      alpha = ($urandom_range(3) == 0) ? 255 : $urandom_range(1, 7);
      for (int k = 0; k < len; k++) begin
        send_plain(8'($urandom_range(alpha)),
                   (k == len - 1) || ($urandom_range(199) == 0));
        count++;
      end
    end

    // One image of random pixels sent with no idling on either side.
    calm = 1;
    for (int k = 0; k < 120; k++) send_plain(8'($urandom_range(255)), k == 119);
    calm = 0;

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (TailWait) @(posedge clk_i);

    $display("Encoded %0d pixels in %0d images, %0d bytes checked.",
             pixels_sent, images_done, bytes_seen);
    $display("Table restarts: %0d, mismatches: %0d.", table_clears, errors);
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
